/* hw/rtl/stp_pkg.sv */
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the set table with random pick: field widths,
// item mode codes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package stp_pkg;

	// Default table depth
	localparam int CAPACITY_DEF = 32;

	// Item field widths
	localparam int MODE_W    = 2;
	localparam int VAL_W     = 32;
	localparam int DRAW_W    = 16;
	localparam int DRAW_IW   = $clog2(DRAW_W);
	localparam int CNT_OUT_W = 6;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PICK   = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // capture the input item
		logic scan_init;   // restart the read pointer at entry zero
		logic scan_step;   // issue the next scan read
		logic shift_init;  // point past the matched entry
		logic shift_step;  // read entry j+1, write it back to entry j
		logic ins_write;   // append the value at the end
		logic cnt_inc;
		logic cnt_dec;
		logic div_init;    // clear the remainder, start at the draw's top bit
		logic div_step;    // one restoring step of draw modulo count
		logic pick_read;   // read the entry at the remainder
		logic respond;     // load the result registers
		logic resp_ok;
		logic resp_pick;   // report the read entry instead of -1
	} stp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              match;
		logic              scan_done;
		logic              shift_done;
		logic              full;
		logic              empty;
		logic              div_last;
	} stp_stat_t;

endpackage

/* hw/rtl/stp_ctrl.sv */
// ----------------------------------------------------------------------------
// stp_ctrl
// Controller of the set table: sequences the scan, shift, modulo and pick
// steps of one item and issues the response.
// ----------------------------------------------------------------------------
module stp_ctrl
	import stp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  stp_stat_t stat,
	output stp_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DISP  = 9'b000000010,
		S_SCAN  = 9'b000000100,
		S_SHIFT = 9'b000001000,
		S_INSW  = 9'b000010000,
		S_DIV   = 9'b000100000,
		S_PREAD = 9'b001000000,
		S_RESP  = 9'b010000000,
		S_SPARE = 9'b100000000
	} stp_state_t;

	stp_state_t state_q, state_d;
	logic       ok_q, ok_d;
	logic       pick_q, pick_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		pick_d  = pick_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				ok_d   = 1'b0;
				pick_d = 1'b0;
				if (stat.mode == MODE_INSERT || stat.mode == MODE_REMOVE) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else if (stat.mode == MODE_PICK && !stat.empty) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.match) begin
					if (stat.mode == MODE_REMOVE) begin
						cmd.shift_init = 1'b1;
						state_d        = S_SHIFT;
					end else begin
						state_d = S_RESP;
					end
				end else if (stat.scan_done) begin
					if (stat.mode == MODE_INSERT && !stat.full) begin
						state_d = S_INSW;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.shift_done) begin
					cmd.cnt_dec = 1'b1;
					ok_d        = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_INSW: begin
				cmd.ins_write = 1'b1;
				cmd.cnt_inc   = 1'b1;
				ok_d          = 1'b1;
				state_d       = S_RESP;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_PREAD;
				end
			end
			S_PREAD: begin
				cmd.pick_read = 1'b1;
				ok_d          = 1'b1;
				pick_d        = 1'b1;
				state_d       = S_RESP;
			end
			S_RESP: begin
				cmd.respond   = 1'b1;
				cmd.resp_ok   = ok_q;
				cmd.resp_pick = pick_q;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and response flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q    <= 1'b0;
			pick_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			pick_q  <= pick_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* hw/rtl/stp_dp.sv */
// ----------------------------------------------------------------------------
// stp_dp
// Datapath of the set table: entry memory with one write and one registered
// read port, read pointer, count, restoring modulo unit and result registers.
// ----------------------------------------------------------------------------
module stp_dp
	import stp_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stp_cmd_t                    cmd,
	output stp_stat_t                   stat,
	input  logic [MODE_W-1:0]           mode,
	input  logic signed [VAL_W-1:0]     value,
	input  logic [DRAW_W-1:0]           random_draw,
	output logic                        done,
	output logic                        ok,
	output logic signed [VAL_W-1:0]     picked_value,
	output logic [CNT_OUT_W-1:0]        stored_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [VAL_W-1:0]     mem [CAPACITY];

	logic [MODE_W-1:0]    mode_q;
	logic [VAL_W-1:0]     value_q;
	logic [DRAW_W-1:0]    draw_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        ptr_q;
	logic [CW-1:0]        rem_q;
	logic [DRAW_IW-1:0]   bit_q;
	logic [VAL_W-1:0]     rd_data_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic                 rd_vld_s1;
	logic                 done_q;
	logic                 ok_q;
	logic [VAL_W-1:0]     picked_q;
	logic [CNT_OUT_W-1:0] stored_q;

	logic                 issue;
	logic                 re;
	logic [AW-1:0]        ra;
	logic                 we;
	logic [AW-1:0]        wa;
	logic [VAL_W-1:0]     wd;
	logic [CW:0]          shifted;
	logic [CW:0]          diff;
	logic [CW-1:0]        rem_d;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	// Read and write port selection
	assign issue = (cmd.scan_step || cmd.shift_step) && (ptr_q < count_q);
	assign re    = issue || cmd.pick_read;
	assign ra    = cmd.pick_read ? rem_q[AW-1:0] : ptr_q[AW-1:0];

	always_comb begin
		we = 1'b0;
		wa = count_q[AW-1:0];
		wd = value_q;
		if (cmd.ins_write) begin
			we = 1'b1;
		end else if (cmd.shift_step && rd_vld_s1) begin
			we = 1'b1;
			wa = rd_idx_s1 - AW'(1);
			wd = rd_data_s1;
		end
	end

	// Entry memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_data_s1 <= mem[ra];
		end
	end

	// One restoring step: bring in the next draw bit, subtract count if it fits
	assign shifted = {rem_q, draw_q[bit_q]};
	assign diff    = shifted - {1'b0, count_q};
	assign rem_d   = (shifted >= {1'b0, count_q}) ? diff[CW-1:0] : shifted[CW-1:0];

	// Capture item, advance pointer, count and modulo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			rem_q     <= '0;
			bit_q     <= '0;
			mode_q    <= '0;
			value_q   <= '0;
			draw_q    <= '0;
		end else begin
			if (cmd.load) begin
				mode_q  <= mode;
				value_q <= value;
				draw_q  <= random_draw;
			end
			if (cmd.scan_init) begin
				ptr_q <= '0;
			end else if (cmd.shift_init) begin
				ptr_q <= CW'(rd_idx_s1) + CW'(1);
			end else if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.scan_init || cmd.shift_init) begin
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
			end
			if (re) begin
				rd_idx_s1 <= ra;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.div_init) begin
				rem_q <= '0;
				bit_q <= DRAW_IW'(DRAW_W - 1);
			end else if (cmd.div_step) begin
				rem_q <= rem_d;
				bit_q <= bit_q - DRAW_IW'(1);
			end
		end
	end

	// Result registers
	assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			ok_q     <= cmd.resp_ok;
			picked_q <= cmd.resp_pick ? rd_data_s1 : '1;
			stored_q <= cnt_ext[CNT_OUT_W-1:0];
		end
	end

	assign done         = done_q;
	assign ok           = ok_q;
	assign picked_value = picked_q;
	assign stored_count = stored_q;

	// Status to the controller
	assign stat.mode       = mode_q;
	assign stat.match      = rd_vld_s1 && (rd_data_s1 == value_q);
	assign stat.scan_done  = (ptr_q == count_q) && !rd_vld_s1;
	assign stat.shift_done = (ptr_q == count_q) && !rd_vld_s1;
	assign stat.full       = (count_q == CW'(CAPACITY));
	assign stat.empty      = (count_q == '0);
	assign stat.div_last   = (bit_q == '0);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count exceeds capacity");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_cnt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && cmd.cnt_dec))
		else $error("count raised and lowered together");

	a_shift_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift_step && rd_vld_s1) |-> (rd_idx_s1 != '0))
		else $error("shift writes below entry zero");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_write |-> (count_q < CW'(CAPACITY)))
		else $error("append into a full table");
`endif

endmodule

/* hw/rtl/set_table_random_pick.sv */
// ----------------------------------------------------------------------------
// set_table_random_pick
// Bounded set of distinct signed values in insertion order with insert,
// order-keeping remove and pick of the entry at draw modulo count.
// ----------------------------------------------------------------------------
// One item at a time: raise start with the item while busy is low. Exactly
// one result per item appears on ok/picked_value/stored_count with done high
// for a single cycle, the first cycle after busy falls; the receiver must take
// it then. An insert or remove holds busy while it scans the entries; a remove
// that finds its value stops the scan at the match, and the shift carries on
// from the next entry. A pick on a non-empty set runs 16 restoring modulo
// steps, one per draw bit, then a memory read. Busy time grows with the count
// because the entry memory has one read port and is scanned one entry per
// cycle. Entries are not cleared at reset; only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
module set_table_random_pick
	import stp_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [MODE_W-1:0]       mode,
	input  logic signed [VAL_W-1:0] value,
	input  logic [DRAW_W-1:0]       random_draw,
	output logic                    done,
	output logic                    ok,
	output logic signed [VAL_W-1:0] picked_value,
	output logic [CNT_OUT_W-1:0]    stored_count
);

	stp_cmd_t  cmd;
	stp_stat_t stat;

	// Sequencer
	stp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Storage and arithmetic
	stp_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.value        (value),
		.random_draw  (random_draw),
		.done         (done),
		.ok           (ok),
		.picked_value (picked_value),
		.stored_count (stored_count)
	);

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for set_table_random_pick. A shadow copy of the set
// predicts every result. The bench drives a short directed list first, then
// random fill, drain and mixed sequences in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
	import stp_pkg::*;

	localparam int DEPTH        = CAPACITY_DEF;
	localparam int HALF_PERIOD  = 5;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TAIL_CYCLES  = 100;
	localparam int MAX_PRINTED  = 40;

	// Unused mode code: the block must do nothing with it
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
	localparam logic signed [VAL_W-1:0] NO_PICK = -1;

	typedef struct {
		logic                    ok;
		logic signed [VAL_W-1:0] picked;
		logic [CNT_OUT_W-1:0]    cnt;
	} set_result_t;

	// Shadow of the set: predicts each result and checks what the block returns
	class set_mirror;
		logic signed [VAL_W-1:0] held[DEPTH];
		int          held_cnt;
		set_result_t due_results[$];
		int          mismatches;
		int          results;
		int          items;
		int          full_refusals;
		int          dup_refusals;
		int          shift_removes;
		int          picks;
		int          empty_picks;

		function new();
			held_cnt      = 0;
			mismatches    = 0;
			results       = 0;
			items         = 0;
			full_refusals = 0;
			dup_refusals  = 0;
			shift_removes = 0;
			picks         = 0;
			empty_picks   = 0;
		endfunction

		function int find(logic signed [VAL_W-1:0] v);
			for (int i = 0; i < held_cnt; i++) begin
				if (held[i] == v)
					return i;
			end
			return -1;
		endfunction

		// Apply one accepted item to the shadow and queue its result
		function void note_item(logic [MODE_W-1:0] m, logic signed [VAL_W-1:0] v,
				logic [DRAW_W-1:0] draw);
			set_result_t r;
			int          pos;
			r.ok     = 1'b0;
			r.picked = NO_PICK;
			items++;
			case (m)
				MODE_INSERT: begin
					pos = find(v);
					if (pos >= 0)
						dup_refusals++;
					else if (held_cnt >= DEPTH)
						full_refusals++;
					else begin
						held[held_cnt] = v;
						held_cnt++;
						r.ok = 1'b1;
					end
				end
				MODE_REMOVE: begin
					pos = find(v);
					if (pos >= 0) begin
						if (pos + 1 < held_cnt)
							shift_removes++;
						for (int j = pos; j + 1 < held_cnt; j++)
							held[j] = held[j + 1];
						held_cnt--;
						r.ok = 1'b1;
					end
				end
				MODE_PICK: begin
					if (held_cnt > 0) begin
						r.picked = held[int'(draw) % held_cnt];
						r.ok     = 1'b1;
						picks++;
					end else
						empty_picks++;
				end
				default: begin
				end
			endcase
			r.cnt = CNT_OUT_W'(held_cnt);
			due_results.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("%0t: mismatch: %s", $time, what);
		endtask

		// Compare one result with the oldest prediction
		task check_result(logic o, logic signed [VAL_W-1:0] p, logic [CNT_OUT_W-1:0] c);
			set_result_t w;
			results++;
			if (due_results.size() == 0) begin
				report($sformatf("result with no item pending (ok=%0b value=%0d count=%0d)",
					o, p, c));
				return;
			end
			w = due_results.pop_front();
			if (o !== w.ok)
				report($sformatf("ok %b, predicted %b", o, w.ok));
			if (p !== w.picked)
				report($sformatf("picked_value %0d, predicted %0d", p, w.picked));
			if (c !== w.cnt)
				report($sformatf("stored_count %0d, predicted %0d", c, w.cnt));
		endtask

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [MODE_W-1:0]       mode = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic [DRAW_W-1:0]       random_draw = '0;
	logic                    busy;
	logic                    done;
	logic                    ok;
	logic signed [VAL_W-1:0] picked_value;
	logic [CNT_OUT_W-1:0]    stored_count;

	set_mirror mirror;
	int        burst_left = 0;
	int        cycles = 0;

	set_table_random_pick #(
		.CAPACITY(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.value(value),
		.random_draw(random_draw),
		.done(done),
		.ok(ok),
		.picked_value(picked_value),
		.stored_count(stored_count)
	);

	always #HALF_PERIOD clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				mirror.pending());
			$display("tb_top: errors");
			$finish;
		end
	end

	// Take each result in the cycle its strobe is high
	always @(posedge clk) begin
		if (arst_n && done)
			mirror.check_result(ok, picked_value, stored_count);
	end

	// Hold start low for a random gap now and then, with junk on the fields
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 14);
				repeat (gap) begin
					start       <= 1'b0;
					mode        <= MODE_W'($urandom);
					value       <= $urandom;
					random_draw <= DRAW_W'($urandom);
					@(posedge clk);
				end
			end
		end
		burst_left--;
	endtask

	// Present one item and hold it until the block takes it
	task automatic send_item(input logic [MODE_W-1:0] m, input logic signed [VAL_W-1:0] v,
			input logic [DRAW_W-1:0] d);
		start       <= 1'b1;
		mode        <= m;
		value       <= v;
		random_draw <= d;
		do
			@(posedge clk);
		while (busy);
		mirror.note_item(m, v, d);
		pace();
	endtask

	function automatic logic signed [VAL_W-1:0] fresh_value();
		logic signed [VAL_W-1:0] v;
		do
			v = $urandom;
		while (mirror.find(v) >= 0);
		return v;
	endfunction

	function automatic logic signed [VAL_W-1:0] held_value();
		if (mirror.held_cnt == 0)
			return $urandom;
		return mirror.held[$urandom_range(0, mirror.held_cnt - 1)];
	endfunction

	// Mix of present values, a small pool of corner values, and anything
	function automatic logic signed [VAL_W-1:0] any_value();
		case ($urandom_range(0, 2))
			0: return held_value();
			1: begin
				case ($urandom_range(0, 5))
					0: return 0;
					1: return -1;
					2: return 1;
					3: return 32'sh8000_0000;
					4: return 32'sh7FFF_FFFF;
					default: return 2;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic mixed_item();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll <= 5)
			send_item(MODE_INSERT, any_value(), DRAW_W'($urandom));
		else if (roll <= 10)
			send_item(MODE_REMOVE, any_value(), DRAW_W'($urandom));
		else if (roll <= 14)
			send_item(MODE_PICK, $urandom, DRAW_W'($urandom));
		else
			send_item(MODE_NONE, any_value(), DRAW_W'($urandom));
	endtask

	initial begin
		int n;
		mirror = new();

		// Reset once
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty set, extremes, duplicate, shifting removes, back to empty
		send_item(MODE_PICK, 0, 16'hFFFF);
		send_item(MODE_REMOVE, 5, 0);
		send_item(MODE_NONE, 0, 0);
		send_item(MODE_INSERT, 32'sh8000_0000, 0);
		send_item(MODE_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
		send_item(MODE_INSERT, 0, 0);
		send_item(MODE_INSERT, -1, 0);
		send_item(MODE_INSERT, 32'sh8000_0000, 0);
		send_item(MODE_PICK, 0, 16'h0000);
		send_item(MODE_PICK, -1, 16'hFFFF);
		send_item(MODE_REMOVE, 32'sh7FFF_FFFF, 0);
		send_item(MODE_PICK, 0, 16'h0001);
		send_item(MODE_REMOVE, 12345, 0);
		send_item(MODE_NONE, -1, 16'hFFFF);
		send_item(MODE_REMOVE, 32'sh8000_0000, 0);
		send_item(MODE_REMOVE, -1, 0);
		send_item(MODE_REMOVE, 0, 0);
		send_item(MODE_PICK, 0, 16'h8000);

		// Random: fill to full and past it, drain in random order, and mixed noise
		while (mirror.items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: begin
					n = DEPTH - mirror.held_cnt + $urandom_range(1, 4);
					repeat (n) begin
						if ($urandom_range(0, 7) == 0)
							send_item(MODE_PICK, $urandom, DRAW_W'($urandom));
						else if ($urandom_range(0, 4) == 0 && mirror.held_cnt > 0)
							send_item(MODE_INSERT, held_value(), DRAW_W'($urandom));
						else
							send_item(MODE_INSERT, fresh_value(), DRAW_W'($urandom));
					end
				end
				1: begin
					n = mirror.held_cnt + $urandom_range(1, 3);
					repeat (n) begin
						if ($urandom_range(0, 7) == 0)
							send_item(MODE_PICK, $urandom, DRAW_W'($urandom));
						else
							send_item(MODE_REMOVE, held_value(), DRAW_W'($urandom));
					end
				end
				default: begin
					repeat ($urandom_range(10, 40))
						mixed_item();
				end
			endcase
		end

		// Drain the outstanding results, then watch for strays
		start <= 1'b0;
		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d items and checked %0d results, %0d mismatches",
			mirror.items, mirror.results, mirror.mismatches);
		$display("seen: %0d picks, %0d on an empty set, %0d full and %0d duplicate refusals, %0d mid-table removes",
			mirror.picks, mirror.empty_picks, mirror.full_refusals, mirror.dup_refusals,
			mirror.shift_removes);
		if (mirror.mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
